### rtl/mpd_pkg.sv
// Shared types and constants for the message packet deframer.
// Used by mpd_parser, mpd_res_fifo and message_packet_deframer.
package mpd_pkg;

    localparam int HEADER_BYTES_DEF = 40;

    // Frame byte counter, saturating at its all-ones value.
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Header field boundaries (byte positions, big-endian fields).
    localparam int MAGIC_END   = 4;
    localparam int VERSION_END = 6;
    localparam int TYPE_END    = 8;
    localparam int FLAGS_END   = 12;
    localparam int LENGTH_END  = 16;
    localparam int VIEW_END    = 24;
    localparam int SERIAL_END  = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] MAGIC_RESET       = 32'd0;
    localparam logic [15:0] VERSION_RESET     = 16'd1;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

    // Output stream packing.
    localparam int OUT_DATA_W = 224;
    localparam int OUT_PAD_W  = 5;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERSIZE   = 3'd1,
        ST_SHORT_HDR  = 3'd2,
        ST_BAD_MAGIC  = 3'd3,
        ST_BAD_VER    = 3'd4,
        ST_LEN_MISM   = 3'd5,
        ST_TYPE_ZERO  = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [15:0] msg_type;
        logic [31:0] msg_flags;
        logic [31:0] declared_length;
        logic [63:0] view_ident;
        logic [63:0] serial_number;
        logic        last_result;
    } result_t;

endpackage

### rtl/mpd_parser.sv
// Frame parser: byte counter, header capture and status checks.
// Produces up to two results per byte. Depends on mpd_pkg.
module mpd_parser #(
    parameter int HEADER_BYTES = mpd_pkg::HEADER_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  mpd_pkg::cfg_t    cfg,
    output logic [1:0]       push_cnt,
    output mpd_pkg::result_t res0,
    output mpd_pkg::result_t res1
);

    localparam logic [mpd_pkg::COUNT_W-1:0] HDR = mpd_pkg::COUNT_W'(HEADER_BYTES);

    logic [mpd_pkg::COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [31:0] magic_reg, magic_next, magic_cap;
    logic [15:0] version_reg, version_next, version_cap;
    logic [15:0] type_reg, type_next, type_cap;
    logic [31:0] flags_reg, flags_next, flags_cap;
    logic [31:0] length_reg, length_next, length_cap;
    logic [63:0] view_reg, view_next, view_cap;
    logic [63:0] serial_reg, serial_next, serial_cap;

    logic                         in_hdr;
    logic [mpd_pkg::COUNT_W:0]    limit;
    logic [32:0]                  expect_len;
    mpd_pkg::status_t             status;
    mpd_pkg::result_t             pay_res, desc_res;

    always_comb
    begin
        in_hdr    = count_reg < HDR;
        count_inc = (count_reg == mpd_pkg::COUNT_MAX) ? count_reg
                                                      : count_reg + 1'b1;

        magic_cap   = magic_reg;
        version_cap = version_reg;
        type_cap    = type_reg;
        flags_cap   = flags_reg;
        length_cap  = length_reg;
        view_cap    = view_reg;
        serial_cap  = serial_reg;
        // Reserved header bytes fall through every branch and are dropped.
        if (in_hdr)
        begin
            if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::MAGIC_END))
                magic_cap = {magic_reg[23:0], in_byte};
            else if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::VERSION_END))
                version_cap = {version_reg[7:0], in_byte};
            else if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::TYPE_END))
                type_cap = {type_reg[7:0], in_byte};
            else if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::FLAGS_END))
                flags_cap = {flags_reg[23:0], in_byte};
            else if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::LENGTH_END))
                length_cap = {length_reg[23:0], in_byte};
            else if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::VIEW_END))
                view_cap = {view_reg[55:0], in_byte};
            else if (count_reg < mpd_pkg::COUNT_W'(mpd_pkg::SERIAL_END))
                serial_cap = {serial_reg[55:0], in_byte};
        end

        // The checks use the count including the closing byte.
        limit      = {1'b0, HDR} + {2'b00, cfg.max_payload};
        expect_len = {16'd0, HDR} + {1'b0, length_cap};
        if ({1'b0, count_inc} > limit)
            status = mpd_pkg::ST_OVERSIZE;
        else if (count_inc < HDR)
            status = mpd_pkg::ST_SHORT_HDR;
        else if (magic_cap != cfg.magic)
            status = mpd_pkg::ST_BAD_MAGIC;
        else if (version_cap != cfg.version)
            status = mpd_pkg::ST_BAD_VER;
        else if ({16'd0, count_inc} != expect_len)
            status = mpd_pkg::ST_LEN_MISM;
        else if (type_cap == 16'd0)
            status = mpd_pkg::ST_TYPE_ZERO;
        else
            status = mpd_pkg::ST_OK;

        pay_res              = '0;
        pay_res.payload_byte = in_byte;

        desc_res                 = '0;
        desc_res.kind            = 1'b1;
        desc_res.status          = status;
        desc_res.msg_type        = type_cap;
        desc_res.msg_flags       = flags_cap;
        desc_res.declared_length = length_cap;
        desc_res.view_ident      = view_cap;
        desc_res.serial_number   = serial_cap;
        desc_res.last_result     = 1'b1;

        if (!fire)
        begin
            push_cnt = 2'd0;
            res0     = pay_res;
            res1     = desc_res;
        end
        else if (in_hdr)
        begin
            push_cnt = {1'b0, in_last};
            res0     = desc_res;
            res1     = desc_res;
        end
        else
        begin
            push_cnt = in_last ? 2'd2 : 2'd1;
            res0     = pay_res;
            res1     = desc_res;
        end

        count_next   = count_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        type_next    = type_reg;
        flags_next   = flags_reg;
        length_next  = length_reg;
        view_next    = view_reg;
        serial_next  = serial_reg;
        if (fire)
        begin
            if (in_last)
            begin
                count_next   = '0;
                magic_next   = '0;
                version_next = '0;
                type_next    = '0;
                flags_next   = '0;
                length_next  = '0;
                view_next    = '0;
                serial_next  = '0;
            end
            else
            begin
                count_next   = count_inc;
                magic_next   = magic_cap;
                version_next = version_cap;
                type_next    = type_cap;
                flags_next   = flags_cap;
                length_next  = length_cap;
                view_next    = view_cap;
                serial_next  = serial_cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            magic_reg   <= '0;
            version_reg <= '0;
            type_reg    <= '0;
            flags_reg   <= '0;
            length_reg  <= '0;
            view_reg    <= '0;
            serial_reg  <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            flags_reg   <= flags_next;
            length_reg  <= length_next;
            view_reg    <= view_next;
            serial_reg  <= serial_next;
        end
    end

endmodule

### rtl/mpd_res_fifo.sv
// Small result queue taking up to two results a cycle and giving one.
// Depends on mpd_pkg.
module mpd_res_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  mpd_pkg::result_t din0,
    input  mpd_pkg::result_t din1,
    input  logic             pop,
    output logic             not_empty,
    output logic             has_room2,
    output logic [mpd_pkg::FIFO_CNT_W-1:0] fill,
    output mpd_pkg::result_t dout
);

    mpd_pkg::result_t mem_reg [mpd_pkg::FIFO_DEPTH];

    logic [mpd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_1;
    logic [mpd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mpd_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_1    = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + mpd_pkg::FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + mpd_pkg::FIFO_PTR_W'(do_pop);
        count_next  = count_reg + mpd_pkg::FIFO_CNT_W'(push_cnt)
                                - mpd_pkg::FIFO_CNT_W'(do_pop);
    end

    assign not_empty = count_reg != '0;
    assign has_room2 = count_reg <= mpd_pkg::FIFO_CNT_W'(mpd_pkg::FIFO_DEPTH - 2);
    assign fill      = count_reg;
    assign dout      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= din0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_1] <= din1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/message_packet_deframer.sv
// Message packet deframer: one datagram byte per transfer in, payload bytes
// and an end-of-packet descriptor out. A byte's first result is offered once
// the byte has passed the input register and the parser has written its results into
// the four-entry result queue. One byte is taken every cycle unless the input
// stalls, which it does while the queue holds more than two results. A closing
// byte past the header yields two results, drained one per cycle while m_tready
// is high. Reset restores register defaults, clears the frame and empties the queue.
module message_packet_deframer #(
    parameter int HEADER_BYTES = mpd_pkg::HEADER_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] in_byte
    input  logic                           s_tlast,  // end_of_datagram
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] payload_byte, [10:8] status, [26:11] msg_type, [58:27] msg_flags,
    // [90:59] declared_length, [154:91] view_ident, [218:155] serial_number
    output logic [mpd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,  // kind
    output logic                           m_tlast,  // last_result
    input  logic                           cfg_we,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data
);

    mpd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             move;
    logic             room2;
    logic             q_not_empty;
    logic [1:0]       push_cnt;
    logic [mpd_pkg::FIFO_CNT_W-1:0] q_fill;
    mpd_pkg::result_t res0, res1, head;

    assign move     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= mpd_pkg::MAGIC_RESET;
            cfg_reg.version     <= mpd_pkg::VERSION_RESET;
            cfg_reg.max_payload <= mpd_pkg::MAX_PAYLOAD_RESET;
            in_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mpd_pkg::CFG_MAGIC:       cfg_reg.magic       <= cfg_data;
                    mpd_pkg::CFG_VERSION:     cfg_reg.version     <= cfg_data[15:0];
                    mpd_pkg::CFG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data[15:0];
                    default:                  ;
                endcase
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mpd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (move),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .cfg      (cfg_reg),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    mpd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .din0      (res0),
        .din1      (res1),
        .pop       (m_tready),
        .not_empty (q_not_empty),
        .has_room2 (room2),
        .fill      (q_fill),
        .dout      (head)
    );

    assign m_tvalid = q_not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last_result;
    assign m_tdata  = {{mpd_pkg::OUT_PAD_W{1'b0}}, head.serial_number, head.view_ident,
                       head.declared_length, head.msg_flags, head.msg_type,
                       head.status, head.payload_byte};

    // A descriptor and only a descriptor closes the datagram.
    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("descriptor kind and last flag disagree");

    // Payload byte results carry no status.
    a_pay_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[10:8] == 3'd0))
        else $error("payload result with non-zero status");

    // The queue never overfills.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_fill <= mpd_pkg::FIFO_CNT_W'(mpd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A held input byte is not lost while the queue lacks room for two results.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> in_valid_reg)
        else $error("stalled input byte dropped");

endmodule

### tb/message_packet_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for message_packet_deframer: drives datagram bytes on the
// input stream, predicts payload transfers and descriptors, and compares every result.
// Depends on mpd_pkg and the message_packet_deframer RTL only.
module message_packet_deframer_tb;

    localparam int HDR           = mpd_pkg::HEADER_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_BYTES   = 25;
    localparam int NCASES        = 15;
    localparam int FIELDS_W      = mpd_pkg::OUT_DATA_W - mpd_pkg::OUT_PAD_W;
    localparam logic [mpd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [15:0] ONES16 = 16'hFFFF;
    localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit                reconfig;
        logic [31:0]       c_magic;
        logic [15:0]       c_version;
        logic [15:0]       c_max;
        logic [31:0]       magic;
        logic [15:0]       version;
        logic [15:0]       mtype;
        logic [31:0]       flags;
        logic [31:0]       dlen;
        logic [63:0]       view;
        logic [63:0]       serial;
        int                nbytes;
        bit                typed;
        mpd_pkg::status_t  st;
    } frame_case_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [mpd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index = mpd_pkg::CFG_MAGIC;
    logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the block's registers and frame state.
    logic [31:0]                 cfg_magic_r   = mpd_pkg::MAGIC_RESET;
    logic [15:0]                 cfg_version_r = mpd_pkg::VERSION_RESET;
    logic [15:0]                 cfg_max_r     = mpd_pkg::MAX_PAYLOAD_RESET;
    logic [mpd_pkg::COUNT_W-1:0] frame_len     = '0;
    logic [31:0]                 cap_magic     = '0;
    logic [15:0]                 cap_version   = '0;
    logic [15:0]                 cap_type      = '0;
    logic [31:0]                 cap_flags     = '0;
    logic [31:0]                 cap_length    = '0;
    logic [63:0]                 cap_view      = '0;
    logic [63:0]                 cap_serial    = '0;

    mpd_pkg::result_t pending[$];
    frame_case_t      frame_cases[NCASES];
    bit               quiet       = 1'b0;
    bit               paused_once = 1'b0;
    int               errors      = 0;
    int               n_checked   = 0;
    int               bytes_in    = 0;
    int               n_datagrams = 0;
    int               n_pauses    = 0;
    int               idle_cycles = 0;
    int               hold_left   = 0;
    logic [7:0]       status_seen = '0;

    message_packet_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic mpd_pkg::status_t frame_status();
        longint unsigned len;
        len = 64'(frame_len);
        if (len > 64'(HDR) + 64'(cfg_max_r))
            return mpd_pkg::ST_OVERSIZE;
        if (len < 64'(HDR))
            return mpd_pkg::ST_SHORT_HDR;
        if (cap_magic != cfg_magic_r)
            return mpd_pkg::ST_BAD_MAGIC;
        if (cap_version != cfg_version_r)
            return mpd_pkg::ST_BAD_VER;
        if (len != 64'(HDR) + 64'(cap_length))
            return mpd_pkg::ST_LEN_MISM;
        if (cap_type == 16'd0)
            return mpd_pkg::ST_TYPE_ZERO;
        return mpd_pkg::ST_OK;
    endfunction

    // Updates the frame mirror for one accepted byte and queues what it causes.
    // A typed status, where given, replaces the computed one on the descriptor.
    function automatic void predict_byte(input logic [7:0] b, input logic l,
                                         input bit typed, input mpd_pkg::status_t st);
        mpd_pkg::result_t r;
        int               pos;
        pos = int'(frame_len);
        if (pos < HDR)
        begin
            if (pos < mpd_pkg::MAGIC_END)
                cap_magic = {cap_magic[23:0], b};
            else if (pos < mpd_pkg::VERSION_END)
                cap_version = {cap_version[7:0], b};
            else if (pos < mpd_pkg::TYPE_END)
                cap_type = {cap_type[7:0], b};
            else if (pos < mpd_pkg::FLAGS_END)
                cap_flags = {cap_flags[23:0], b};
            else if (pos < mpd_pkg::LENGTH_END)
                cap_length = {cap_length[23:0], b};
            else if (pos < mpd_pkg::VIEW_END)
                cap_view = {cap_view[55:0], b};
            else if (pos < mpd_pkg::SERIAL_END)
                cap_serial = {cap_serial[55:0], b};
        end
        else
        begin
            r = '0;
            r.payload_byte = b;
            pending.push_back(r);
        end
        if (frame_len != mpd_pkg::COUNT_MAX)
            frame_len = frame_len + 1'b1;
        if (l)
        begin
            r = '0;
            r.kind            = 1'b1;
            r.status          = typed ? st : frame_status();
            r.msg_type        = cap_type;
            r.msg_flags       = cap_flags;
            r.declared_length = cap_length;
            r.view_ident      = cap_view;
            r.serial_number   = cap_serial;
            r.last_result     = 1'b1;
            pending.push_back(r);
            frame_len   = '0;
            cap_magic   = '0;
            cap_version = '0;
            cap_type    = '0;
            cap_flags   = '0;
            cap_length  = '0;
            cap_view    = '0;
            cap_serial  = '0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [319:0] build_header(
        input logic [31:0] magic, input logic [15:0] version, input logic [15:0] mtype,
        input logic [31:0] flags, input logic [31:0] dlen, input logic [63:0] view,
        input logic [63:0] serial, input logic [63:0] rsv);
        return {magic, version, mtype, flags, dlen, view, serial, rsv};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l,
                             input bit typed, input mpd_pkg::status_t st);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b, l, typed, st);
        bytes_in++;
    endtask

    // Holds the input off until every queued result has gone, then lets the
    // pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [31:0] magic, input logic [15:0] version,
                                input logic [15:0] max_payload);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= mpd_pkg::CFG_MAGIC;
        cfg_data  <= magic;
        @(posedge clk);
        // Upper bits of the narrow registers must be dropped by the block.
        cfg_index <= mpd_pkg::CFG_VERSION;
        cfg_data  <= {16'($urandom), version};
        @(posedge clk);
        cfg_index <= mpd_pkg::CFG_MAX_PAYLOAD;
        cfg_data  <= {16'($urandom), max_payload};
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_magic_r   = magic;
        cfg_version_r = version;
        cfg_max_r     = max_payload;
    endtask

    task automatic send_datagram(input logic [319:0] hdr, input int nbytes,
                                 input bit typed, input mpd_pkg::status_t st,
                                 input int pause_at);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++)
        begin
            if (i == pause_at)
            begin
                wait_drained();
                n_pauses++;
            end
            b = (i < HDR) ? hdr[319 - 8*i -: 8] : 8'($urandom);
            send_byte(b, i == nbytes - 1, typed, st);
        end
        n_datagrams++;
    endtask

    // Mostly well-formed datagrams for the current settings, the rest carry
    // one defect each or are plain noise.
    task automatic random_datagram();
        logic [31:0] magic;
        logic [31:0] flags;
        logic [31:0] dlen;
        logic [15:0] version;
        logic [15:0] mtype;
        logic [63:0] view;
        logic [63:0] serial;
        logic [63:0] rsv;
        int          nbytes;
        int          kind_sel;
        int          pause_at;
        int          lim;
        lim      = (cfg_max_r < 16'd12) ? int'(cfg_max_r) : 12;
        magic    = cfg_magic_r;
        version  = cfg_version_r;
        mtype    = 16'($urandom_range(1, 65535));
        flags    = $urandom;
        dlen     = $urandom_range(0, lim);
        view     = {$urandom, $urandom};
        serial   = {$urandom, $urandom};
        rsv      = {$urandom, $urandom};
        nbytes   = HDR + int'(dlen);
        kind_sel = $urandom_range(0, 99);
        if (kind_sel < 60)
            nbytes = nbytes;
        else if (kind_sel < 70)
            nbytes = $urandom_range(1, HDR - 1);
        else if (kind_sel < 75)
            magic = magic ^ (32'd1 << $urandom_range(0, 31));
        else if (kind_sel < 80)
            version = version ^ (16'd1 << $urandom_range(0, 15));
        else if (kind_sel < 87)
        begin
            if ($urandom_range(0, 1) == 1)
                nbytes = nbytes + $urandom_range(1, 3);
            else
                dlen = $urandom;
        end
        else if (kind_sel < 92)
            mtype = 16'd0;
        else if (kind_sel < 96)
        begin
            if (cfg_max_r <= 16'd24)
                nbytes = HDR + int'(cfg_max_r) + $urandom_range(1, 3);
            else
                dlen = dlen + 1;
        end
        else
        begin
            magic   = $urandom;
            version = 16'($urandom);
            mtype   = 16'($urandom);
            dlen    = $urandom;
            nbytes  = $urandom_range(1, 60);
        end
        pause_at = -1;
        if (!paused_once || $urandom_range(0, 7) == 0)
            pause_at = $urandom_range(0, nbytes - 1);
        paused_once = 1'b1;
        quiet = ($urandom_range(0, 4) == 0);
        send_datagram(build_header(magic, version, mtype, flags, dlen, view, serial, rsv),
                      nbytes, 1'b0, mpd_pkg::ST_OK, pause_at);
    endtask

    always @(posedge clk)
    begin : ready_gen
        int r;
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                m_tready  <= 1'b1;
                hold_left <= 0;
            end
            else if (r < 63)
            begin
                m_tready  <= 1'b1;
                hold_left <= $urandom_range(30, 200);
            end
            else if (r < 95)
            begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(0, 2);
            end
            else
            begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        mpd_pkg::result_t got;
        mpd_pkg::result_t want;
        if (m_tvalid && m_tready)
        begin
            got.kind            = m_tuser;
            got.payload_byte    = m_tdata[7:0];
            got.status          = mpd_pkg::status_t'(m_tdata[10:8]);
            got.msg_type        = m_tdata[26:11];
            got.msg_flags       = m_tdata[58:27];
            got.declared_length = m_tdata[90:59];
            got.view_ident      = m_tdata[154:91];
            got.serial_number   = m_tdata[218:155];
            got.last_result     = m_tlast;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result transfer with nothing expected: tuser %0d tdata %h",
                             m_tuser, m_tdata);
            end
            else
            begin
                want = pending.pop_front();
                n_checked++;
                if (want.kind)
                    status_seen[want.status] = 1'b1;
                if (got !== want || m_tdata[mpd_pkg::OUT_DATA_W-1:FIELDS_W] !== '0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR: result %0d (expected/actual) kind %0d/%0d byte %h/%h",
                                 n_checked, want.kind, got.kind,
                                 want.payload_byte, got.payload_byte,
                                 " status %0d/%0d last %0d/%0d", want.status, got.status,
                                 want.last_result, got.last_result);
                        $display("       type %h/%h flags %h/%h length %h/%h",
                                 want.msg_type, got.msg_type, want.msg_flags, got.msg_flags,
                                 want.declared_length, got.declared_length);
                        $display("       view %h/%h serial %h/%h pad %h",
                                 want.view_ident, got.view_ident,
                                 want.serial_number, got.serial_number,
                                 m_tdata[mpd_pkg::OUT_DATA_W-1:FIELDS_W]);
                    end
                end
            end
        end
    end

    // Ends the run when neither stream has moved for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("message_packet_deframer_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        frame_case_t fc;
        logic [31:0] ph_magic;
        logic [15:0] ph_version;
        logic [15:0] ph_max;
        int          phase_start;

        // Rows up to the first reconfiguration run with the register defaults.
        frame_cases = '{
            '{0, 0, 0, 0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0, 64'd0, 64'd0,
              1, 1, mpd_pkg::ST_SHORT_HDR},
            '{0, 0, 0, 0, ONES32, ONES16, ONES16, ONES32, ONES32, ONES64, ONES64,
              10, 1, mpd_pkg::ST_SHORT_HDR},
            '{0, 0, 0, 0, 32'd0, 16'd1, 16'd1, 32'd0, 32'd0, 64'd0, 64'd0,
              39, 1, mpd_pkg::ST_SHORT_HDR},
            '{0, 0, 0, 0, 32'd0, 16'd1, 16'd1, 32'd0, 32'd0, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_OK},
            '{0, 0, 0, 0, ONES32, 16'd1, 16'd1, 32'd0, 32'd0, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_BAD_MAGIC},
            '{0, 0, 0, 0, 32'd0, 16'd0, 16'd1, 32'd0, 32'd0, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_BAD_VER},
            '{0, 0, 0, 0, 32'd0, ONES16, 16'd1, 32'd0, 32'd0, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_BAD_VER},
            '{0, 0, 0, 0, 32'd0, 16'd1, 16'd1, 32'd0, 32'd5, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_LEN_MISM},
            '{0, 0, 0, 0, 32'd0, 16'd1, 16'd0, 32'd0, 32'd0, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_TYPE_ZERO},
            '{0, 0, 0, 0, 32'd0, 16'd1, ONES16, ONES32, 32'd3, ONES64, ONES64,
              43, 1, mpd_pkg::ST_OK},
            '{0, 0, 0, 0, 32'd0, 16'd1, 16'd1, 32'd0, ONES32, 64'd0, 64'd0,
              42, 1, mpd_pkg::ST_LEN_MISM},
            '{1, ONES32, ONES16, 16'd0, ONES32, ONES16, 16'd1, 32'd0, 32'd1, 64'd0, 64'd0,
              41, 1, mpd_pkg::ST_OVERSIZE},
            '{0, 0, 0, 0, ONES32, ONES16, 16'd1, 32'd0, 32'd0, 64'd0, 64'd0,
              40, 1, mpd_pkg::ST_OK},
            '{1, 32'h1234_5678, 16'd0, 16'd2, 32'h1234_5678, 16'd0, 16'h8000,
              32'h8000_0001, 32'd2, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
              42, 1, mpd_pkg::ST_OK},
            // Oversize is checked ahead of the magic word.
            '{0, 0, 0, 0, 32'd0, 16'd0, 16'd1, 32'd0, 32'd3, 64'd0, 64'd0,
              43, 1, mpd_pkg::ST_OVERSIZE}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NCASES; k++)
        begin
            fc = frame_cases[k];
            if (fc.reconfig)
                apply_config(fc.c_magic, fc.c_version, fc.c_max);
            quiet = ($urandom_range(0, 3) == 0);
            send_datagram(build_header(fc.magic, fc.version, fc.mtype, fc.flags, fc.dlen,
                                       fc.view, fc.serial, {$urandom, $urandom}),
                          fc.nbytes, fc.typed, fc.st, -1);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                ph_magic   = 32'd0;
                ph_version = ONES16;
                ph_max     = 16'd0;
            end
            else if (ph == 1)
            begin
                ph_magic   = ONES32;
                ph_version = 16'd0;
                ph_max     = ONES16;
            end
            else
            begin
                ph_magic   = $urandom;
                ph_version = 16'($urandom);
                ph_max     = 16'($urandom_range(1, 24));
            end
            apply_config(ph_magic, ph_version, ph_max);
            phase_start = bytes_in;
            while (bytes_in - phase_start < PHASE_BYTES)
                random_datagram();
        end

        wait_drained();
        $display("Ran %0d datagrams (%0d bytes in) with %0d mid-frame pauses.",
                 n_datagrams, bytes_in, n_pauses);
        $display("Checked %0d results; descriptor status codes seen (bit per code): %b.",
                 n_checked, status_seen);
        if (errors == 0)
            $display("message_packet_deframer_tb: clean");
        else
            $display("message_packet_deframer_tb: errors");
        $finish;
    end

endmodule
